FILE: sv/mrb_pkg.sv
// mrb_pkg: shared constants, operation and status codes and the result record
// for the message ring buffer. No dependencies.

package mrb_pkg;

	localparam int CAPACITY     = 4096;
	localparam int HEADER_BYTES = 4;

	localparam int OP_W     = 2;
	localparam int SIZE_W   = 12;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_START  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] STS_NO_MSG    = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   data;
		logic                last;
		logic                empty;
		logic                over;
	} res_t;

endpackage

FILE: sv/mrb_store.sv
// mrb_store: byte memory of the ring, one write port and one read port with
// registered read data. Depends on mrb_pkg for the byte width and the default depth.

module mrb_store #(
	parameter int DEPTH = mrb_pkg::CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [mrb_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [mrb_pkg::DATA_W-1:0] rdata
);

	logic [mrb_pkg::DATA_W-1:0] mem [DEPTH];
	logic [mrb_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/mrb_ptr_alu.sv
// mrb_ptr_alu: shared modular pointer adder of the ring, plus the used byte
// count between the read and commit pointers. Depends on mrb_pkg.

module mrb_ptr_alu #(
	parameter int CAPACITY = mrb_pkg::CAPACITY,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic [AW-1:0] a,
	input  logic [AW-1:0] b,
	input  logic [AW-1:0] rd_ptr,
	input  logic [AW-1:0] cm_ptr,
	output logic [AW-1:0] sum,
	output logic [AW-1:0] used
);

	localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);

	logic [AW:0] raw_sum;
	logic [AW:0] raw_diff;

	// both operands stay below the capacity, so one subtract wraps
	always_comb begin
		raw_sum = {1'b0, a} + {1'b0, b};
		if (raw_sum >= CAP_W) begin
			raw_sum = raw_sum - CAP_W;
		end
		sum = raw_sum[AW-1:0];
	end

	always_comb begin
		raw_diff = {1'b0, cm_ptr} - {1'b0, rd_ptr};
		if (cm_ptr < rd_ptr) begin
			raw_diff = raw_diff + CAP_W;
		end
		used = raw_diff[AW-1:0];
	end

endmodule

FILE: sv/message_ring_buffer.sv
// message_ring_buffer: top level, sequencer over the shared pointer adder and
// the byte store. Depends on mrb_pkg, mrb_ptr_alu and mrb_store.
//
//  channel  handshake           payload
//  input    in_valid/in_stall   operation, message_size, data_in
//  output   out_valid/out_stall status, data_out, last_of_message,
//                               empty_message, overwrote_old
//
// one item at a time: each append, read or start runs through its states before the
// next item is taken; the first read of a message also reads its header, and a start
// drops the oldest messages (the rest of a partly read one) until the new one fits or
// the ring is empty; one pointer adder and the single store read port are shared
// arst_n clears pointers and counters; the store is not cleared
// in_stall is high from acceptance until the result sits in the output
// register; a stalled output only holds a finished result

module message_ring_buffer #(
	parameter int CAPACITY     = mrb_pkg::CAPACITY,
	parameter int HEADER_BYTES = mrb_pkg::HEADER_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mrb_pkg::OP_W-1:0]      operation,
	input  logic [mrb_pkg::SIZE_W-1:0]    message_size,
	input  logic [mrb_pkg::DATA_W-1:0]    data_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mrb_pkg::STATUS_W-1:0]  status,
	output logic [mrb_pkg::DATA_W-1:0]    data_out,
	output logic                          last_of_message,
	output logic                          empty_message,
	output logic                          overwrote_old
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int HIW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
	localparam logic [AW-1:0]  LAST_PTR = AW'(CAPACITY - 1);
	localparam logic [AW-1:0]  HDR_LEN  = AW'(HEADER_BYTES);
	localparam logic [HIW-1:0] HIDX_END = HIW'(HEADER_BYTES - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_DROP, ST_HRD_A, ST_HRD_D, ST_DROP_APPLY, ST_HWR,
		ST_APPEND, ST_READ, ST_RD_HDR, ST_RD_A, ST_RD_D, ST_RESP
	} state_t;

	state_t state_q;

	logic [mrb_pkg::SIZE_W-1:0] size_q;
	logic [mrb_pkg::DATA_W-1:0] data_q;
	logic [AW-1:0]              wp_q, cp_q, rp_q;
	logic [mrb_pkg::SIZE_W-1:0] wrem_q;
	logic [AW-1:0]              rrem_q;
	logic                       rim_q;
	logic [HIW-1:0]             hidx_q;
	logic [31:0]                hdr_q;
	logic                       hdr_for_read_q;
	mrb_pkg::res_t              res_q, out_q;
	logic                       out_valid_q;
	logic                       out_load;

	logic [AW-1:0] alu_a, alu_b, alu_sum, used;
	logic [AW-1:0] free_bytes;
	logic [31:0]   size_w, need_w;
	logic          too_big;
	logic [32:0]   hdr_step;
	logic [AW-1:0] drop_step;
	logic [AW-1:0] room;
	logic [AW-1:0] rd_len;
	logic          mem_we, mem_re;
	logic [mrb_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
	logic [31:0]   size_shift;

	mrb_ptr_alu #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.rd_ptr(rp_q),
		.cm_ptr(cp_q),
		.sum   (alu_sum),
		.used  (used)
	);

	mrb_store #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wp_q),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(alu_sum),
		.rdata(mem_rdata)
	);

	always_comb begin
		free_bytes = LAST_PTR - used;
		size_w     = 32'(size_q);
		need_w     = size_w + 32'(HEADER_BYTES);
		too_big    = (need_w > 32'(CAPACITY - 1)) || ((size_w >> (8 * HEADER_BYTES)) != 32'd0);
		hdr_step   = {1'b0, hdr_q} + 33'(HEADER_BYTES);
		// a partly read message drops what is left of it, otherwise header plus length
		if (rim_q) begin
			drop_step = (rrem_q > used) ? used : rrem_q;
		end else begin
			drop_step = (hdr_step > 33'(used)) ? used : hdr_step[AW-1:0];
		end
		room       = (used > HDR_LEN) ? (used - HDR_LEN) : '0;
		rd_len     = (hdr_q > 32'(room)) ? room : hdr_q[AW-1:0];
		size_shift = size_w >> {hidx_q, 3'b000};
	end

	always_comb begin
		alu_a = rp_q;
		alu_b = '0;
		case (state_q)
			ST_DROP, ST_DROP_APPLY: alu_b = drop_step;
			ST_HRD_A:               alu_b = AW'(hidx_q);
			ST_HWR, ST_APPEND: begin
				alu_a = wp_q;
				alu_b = AW'(1);
			end
			ST_RD_HDR:              alu_b = HDR_LEN;
			ST_RD_D:                alu_b = AW'(1);
			default:                alu_b = '0;
		endcase
	end

	assign mem_we    = (state_q == ST_HWR) || ((state_q == ST_APPEND) && (wrem_q != '0));
	assign mem_wdata = (state_q == ST_HWR) ? size_shift[7:0] : data_q;
	assign mem_re    = (state_q == ST_HRD_A) || (state_q == ST_RD_A);
	assign out_load  = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			size_q         <= '0;
			data_q         <= '0;
			wp_q           <= '0;
			cp_q           <= '0;
			rp_q           <= '0;
			wrem_q         <= '0;
			rrem_q         <= '0;
			rim_q          <= 1'b0;
			hidx_q         <= '0;
			hdr_q          <= '0;
			hdr_for_read_q <= 1'b0;
			res_q          <= '0;
			out_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						size_q <= message_size;
						data_q <= data_in;
						res_q  <= '0;
						case (operation)
							mrb_pkg::OP_START:  state_q <= ST_START;
							mrb_pkg::OP_APPEND: state_q <= ST_APPEND;
							mrb_pkg::OP_READ:   state_q <= ST_READ;
							default:            state_q <= ST_RESP;
						endcase
					end
				end
				ST_START: begin
					if (too_big) begin
						res_q.status <= mrb_pkg::STS_TOO_LARGE;
						state_q      <= ST_RESP;
					end else begin
						// an unfinished message is thrown away
						wp_q    <= cp_q;
						wrem_q  <= '0;
						state_q <= ST_DROP;
					end
				end
				ST_DROP: begin
					if ((need_w > 32'(free_bytes)) && (rp_q != cp_q)) begin
						res_q.over <= 1'b1;
						if (rim_q) begin
							rp_q   <= alu_sum;
							rim_q  <= 1'b0;
							rrem_q <= '0;
						end else begin
							hidx_q         <= '0;
							hdr_q          <= '0;
							hdr_for_read_q <= 1'b0;
							state_q        <= ST_HRD_A;
						end
					end else begin
						if (rp_q == cp_q) begin
							rim_q  <= 1'b0;
							rrem_q <= '0;
						end
						hidx_q  <= '0;
						state_q <= ST_HWR;
					end
				end
				ST_HRD_A: begin
					state_q <= ST_HRD_D;
				end
				ST_HRD_D: begin
					hdr_q <= hdr_q | (32'(mem_rdata) << {hidx_q, 3'b000});
					if (hidx_q == HIDX_END) begin
						state_q <= hdr_for_read_q ? ST_RD_HDR : ST_DROP_APPLY;
					end else begin
						hidx_q  <= hidx_q + HIW'(1);
						state_q <= ST_HRD_A;
					end
				end
				ST_DROP_APPLY: begin
					rp_q    <= alu_sum;
					state_q <= ST_DROP;
				end
				ST_HWR: begin
					wp_q <= alu_sum;
					if (hidx_q == HIDX_END) begin
						wrem_q <= size_q;
						if (size_q == '0) begin
							cp_q <= alu_sum;
						end
						state_q <= ST_RESP;
					end else begin
						hidx_q <= hidx_q + HIW'(1);
					end
				end
				ST_APPEND: begin
					if (wrem_q == '0) begin
						res_q.status <= mrb_pkg::STS_NO_MSG;
					end else begin
						wp_q   <= alu_sum;
						wrem_q <= wrem_q - mrb_pkg::SIZE_W'(1);
						if (wrem_q == mrb_pkg::SIZE_W'(1)) begin
							cp_q <= alu_sum;
						end
					end
					state_q <= ST_RESP;
				end
				ST_READ: begin
					if (rim_q) begin
						state_q <= ST_RD_A;
					end else if (rp_q == cp_q) begin
						res_q.status <= mrb_pkg::STS_EMPTY;
						state_q      <= ST_RESP;
					end else begin
						hidx_q         <= '0;
						hdr_q          <= '0;
						hdr_for_read_q <= 1'b1;
						state_q        <= ST_HRD_A;
					end
				end
				ST_RD_HDR: begin
					rp_q <= alu_sum;
					if (rd_len == '0) begin
						res_q.empty <= 1'b1;
						res_q.last  <= 1'b1;
						state_q     <= ST_RESP;
					end else begin
						rim_q   <= 1'b1;
						rrem_q  <= rd_len;
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: begin
					state_q <= ST_RD_D;
				end
				ST_RD_D: begin
					res_q.data <= mem_rdata;
					rp_q       <= alu_sum;
					if (rrem_q != '0) begin
						rrem_q <= rrem_q - AW'(1);
					end
					if (rrem_q <= AW'(1)) begin
						rim_q      <= 1'b0;
						res_q.last <= 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_load) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign data_out        = out_q.data;
	assign last_of_message = out_q.last;
	assign empty_message   = out_q.empty;
	assign overwrote_old   = out_q.over;

	// a message being read always has bytes left
	assert property (@(posedge clk) disable iff (!arst_n) rim_q |-> (rrem_q != '0))
		else $error("read in message with no bytes left");

	// an open message has its header written past the commit point
	assert property (@(posedge clk) disable iff (!arst_n) (wrem_q != '0) |-> (wp_q != cp_q))
		else $error("open message without header");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rp_q <= LAST_PTR) && (wp_q <= LAST_PTR) && (cp_q <= LAST_PTR))
		else $error("ring pointer out of range");

	// a result waiting on a stalled output is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result overwritten");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for message_ring_buffer, one file, no external files
// depends on mrb_pkg and message_ring_buffer; predicts every result in step with the input

module tb;

	localparam int CAPACITY     = mrb_pkg::CAPACITY;
	localparam int HEADER_BYTES = mrb_pkg::HEADER_BYTES;
	localparam int OP_W         = mrb_pkg::OP_W;
	localparam int SIZE_W       = mrb_pkg::SIZE_W;
	localparam int DATA_W       = mrb_pkg::DATA_W;
	localparam int STATUS_W     = mrb_pkg::STATUS_W;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int PTR_W       = $clog2(CAPACITY);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 200;

	typedef logic [PTR_W-1:0] ptr_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                in_valid        = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     operation       = '0;
	logic [SIZE_W-1:0]   message_size    = '0;
	logic [DATA_W-1:0]   data_in         = '0;
	logic                out_valid;
	logic                out_stall       = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   data_out;
	logic                last_of_message;
	logic                empty_message;
	logic                overwrote_old;

	// shadow of the ring held by the predictor
	logic [DATA_W-1:0] ring_bytes [CAPACITY];
	ptr_t              wr_ptr     = '0;
	ptr_t              commit_ptr = '0;
	ptr_t              rd_ptr     = '0;
	logic [SIZE_W-1:0] wr_left    = '0;
	logic [SIZE_W-1:0] rd_left    = '0;
	logic              rd_open    = 1'b0;

	mrb_pkg::res_t expected_results [$];
	int   mismatch_count = 0;
	int   counted_items  = 0;
	int   cycle_count    = 0;
	int   in_idle_pct    = 0;
	int   out_stall_pct  = 0;
	int   hold_left      = 0;

	message_ring_buffer u_top (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: a long hold-off when asked, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < out_stall_pct);
		end
	end

	always @(posedge clk) begin
		mrb_pkg::res_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing expected");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatch_count++;
				end
				if (data_out !== want.data) begin
					$error("data_out: expected %0h, got %0h", want.data, data_out);
					mismatch_count++;
				end
				if (last_of_message !== want.last) begin
					$error("last_of_message: expected %0b, got %0b", want.last,
						last_of_message);
					mismatch_count++;
				end
				if (empty_message !== want.empty) begin
					$error("empty_message: expected %0b, got %0b", want.empty,
						empty_message);
					mismatch_count++;
				end
				if (overwrote_old !== want.over) begin
					$error("overwrote_old: expected %0b, got %0b", want.over,
						overwrote_old);
					mismatch_count++;
				end
			end
		end
	end

	function automatic ptr_t ring_free();
		return rd_ptr - commit_ptr - ptr_t'(1);
	endfunction

	function automatic ptr_t ring_used();
		return commit_ptr - rd_ptr;
	endfunction

	function automatic logic [31:0] ring_header(ptr_t p);
		logic [31:0] v;
		int          i;
		v = '0;
		for (i = 0; i < HEADER_BYTES; i++)
			v |= 32'(ring_bytes[ptr_t'(p + i)]) << (8 * i);
		return v;
	endfunction

	// drop the oldest message, or what is left of the one being read
	function automatic void drop_oldest_message();
		longint unsigned step;
		ptr_t            used;
		used = ring_used();
		if (rd_open) begin
			step    = rd_left;
			rd_open = 1'b0;
			rd_left = '0;
		end else begin
			step = HEADER_BYTES + ring_header(rd_ptr);
		end
		if (step > used)
			step = used;
		rd_ptr = rd_ptr + ptr_t'(step);
	endfunction

	function automatic mrb_pkg::res_t predict_result(logic [OP_W-1:0] op,
		logic [SIZE_W-1:0] size, logic [DATA_W-1:0] data);
		mrb_pkg::res_t r;
		int unsigned   need;
		logic [31:0]   len;
		int unsigned   room;
		ptr_t          used;
		logic          got;
		int            i;
		r = '0;
		case (op)
			mrb_pkg::OP_START: begin
				need = size + HEADER_BYTES;
				if (need > CAPACITY - 1) begin
					r.status = mrb_pkg::STS_TOO_LARGE;
				end else begin
					// an unfinished message is thrown away
					wr_ptr  = commit_ptr;
					wr_left = '0;
					while (need > ring_free() && rd_ptr != commit_ptr) begin
						drop_oldest_message();
						r.over = 1'b1;
					end
					if (rd_ptr == commit_ptr) begin
						rd_open = 1'b0;
						rd_left = '0;
					end
					for (i = 0; i < HEADER_BYTES; i++) begin
						ring_bytes[wr_ptr] = 8'(32'(size) >> (8 * i));
						wr_ptr = wr_ptr + ptr_t'(1);
					end
					wr_left = size;
					if (size == 0)
						commit_ptr = wr_ptr;
				end
			end
			mrb_pkg::OP_APPEND: begin
				if (wr_left == 0) begin
					r.status = mrb_pkg::STS_NO_MSG;
				end else begin
					ring_bytes[wr_ptr] = data;
					wr_ptr = wr_ptr + ptr_t'(1);
					wr_left--;
					if (wr_left == 0)
						commit_ptr = wr_ptr;
				end
			end
			mrb_pkg::OP_READ: begin
				got = 1'b1;
				if (!rd_open) begin
					if (rd_ptr == commit_ptr) begin
						r.status = mrb_pkg::STS_EMPTY;
						got      = 1'b0;
					end else begin
						len    = ring_header(rd_ptr);
						used   = ring_used();
						room   = used - ((HEADER_BYTES < used) ? HEADER_BYTES : used);
						rd_ptr = rd_ptr + ptr_t'(HEADER_BYTES);
						if (len > room)
							len = room;
						if (len == 0) begin
							r.empty = 1'b1;
							r.last  = 1'b1;
							got     = 1'b0;
						end else begin
							rd_open = 1'b1;
							rd_left = len[SIZE_W-1:0];
						end
					end
				end
				if (got && rd_open) begin
					r.data = ring_bytes[rd_ptr];
					rd_ptr = rd_ptr + ptr_t'(1);
					if (rd_left > 0)
						rd_left--;
					if (rd_left == 0) begin
						rd_open = 1'b0;
						r.last  = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
		input logic [DATA_W-1:0] data);
		mrb_pkg::res_t r;
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		message_size <= size;
		data_in      <= data;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		r = predict_result(op, size, data);
		expected_results.push_back(r);
		if (op != OP_UNUSED && r.status != mrb_pkg::STS_NO_MSG &&
			r.status != mrb_pkg::STS_TOO_LARGE)
			counted_items++;
		@(negedge clk);
	endtask

	task automatic send_read();
		send_item(mrb_pkg::OP_READ, SIZE_W'($urandom), DATA_W'($urandom));
	endtask

	task automatic send_message(input int size, input int read_pct);
		int i;
		send_item(mrb_pkg::OP_START, SIZE_W'(size), DATA_W'($urandom));
		for (i = 0; i < size; i++) begin
			if ($urandom_range(0, 99) < read_pct)
				send_read();
			send_item(mrb_pkg::OP_APPEND, SIZE_W'($urandom), DATA_W'($urandom));
		end
	endtask

	function automatic int pick_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 30)
			return 0;
		if (p < 60)
			return $urandom_range(1, 4);
		if (p < 92)
			return $urandom_range(5, 24);
		return $urandom_range(25, 150);
	endfunction

	task automatic test_directed();
		in_idle_pct   = 0;
		out_stall_pct = 0;
		send_read();
		send_item(mrb_pkg::OP_APPEND, '0, 8'hff);
		send_item(OP_UNUSED, '1, '1);
		send_item(mrb_pkg::OP_START, '1, '0);
		send_item(mrb_pkg::OP_START, SIZE_W'(CAPACITY - HEADER_BYTES), '0);
		send_item(mrb_pkg::OP_START, '0, '0);
		send_read();
		send_item(mrb_pkg::OP_START, SIZE_W'(3), '0);
		send_item(mrb_pkg::OP_APPEND, '0, 8'h00);
		send_item(mrb_pkg::OP_APPEND, '0, 8'hff);
		send_item(mrb_pkg::OP_APPEND, '0, 8'ha5);
		send_read();
		send_read();
		// largest message that fits drops the one part way through being read
		send_item(mrb_pkg::OP_START, SIZE_W'(CAPACITY - 1 - HEADER_BYTES), '0);
		send_item(mrb_pkg::OP_APPEND, '0, 8'h12);
		send_item(mrb_pkg::OP_START, SIZE_W'(2), '0);
		send_item(mrb_pkg::OP_APPEND, '0, 8'h55);
		send_item(mrb_pkg::OP_APPEND, '0, 8'haa);
		send_item(mrb_pkg::OP_START, SIZE_W'(1), '0);
		send_item(mrb_pkg::OP_APPEND, '0, 8'h80);
		repeat (4)
			send_read();
	endtask

	task automatic test_traffic(input int n, input int idle_pct, input int stall_pct);
		int goal;
		int pick;
		in_idle_pct   = idle_pct;
		out_stall_pct = stall_pct;
		goal          = counted_items + n;
		while (counted_items < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_item(OP_W'($urandom_range(0, 3)), SIZE_W'($urandom), DATA_W'($urandom));
			end else if (pick < 12) begin
				// big start left unfinished, forces old messages out
				send_item(mrb_pkg::OP_START,
					SIZE_W'($urandom_range(6, CAPACITY - 1 - HEADER_BYTES)),
					DATA_W'($urandom));
				repeat ($urandom_range(0, 5))
					send_item(mrb_pkg::OP_APPEND, SIZE_W'($urandom), DATA_W'($urandom));
			end else if (pick < 35) begin
				repeat ($urandom_range(1, 12))
					send_read();
			end else begin
				send_message(pick_size(), 15);
			end
		end
	endtask

	// mostly short messages so the ring wraps; steers one header across the end
	task automatic test_wrap(input int n);
		int goal;
		int pick;
		int steer;
		in_idle_pct   = 38;
		out_stall_pct = 38;
		goal          = counted_items + n;
		while (counted_items < goal) begin
			if (commit_ptr + 40 >= CAPACITY && commit_ptr + 2 + HEADER_BYTES <= CAPACITY) begin
				send_item(mrb_pkg::OP_START, SIZE_W'(CAPACITY - 1 - HEADER_BYTES),
					DATA_W'($urandom));
				steer = CAPACITY - 2 - HEADER_BYTES - commit_ptr;
				send_message(steer, 0);
				send_message(3, 0);
				repeat ((steer == 0) ? 1 : steer)
					send_read();
				repeat (3)
					send_read();
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					repeat ($urandom_range(1, 4))
						send_read();
				else if (pick < 25)
					send_message($urandom_range(1, 3), 0);
				else
					send_message(0, 0);
			end
		end
	endtask

	task automatic test_backpressure();
		int goal;
		in_idle_pct   = 0;
		out_stall_pct = 20;
		goal          = counted_items + 120;
		in_valid <= 1'b0;
		@(posedge clk);
		hold_left = 400;
		@(negedge clk);
		while (counted_items < goal) begin
			send_message(pick_size(), 25);
			repeat ($urandom_range(0, 4))
				send_read();
		end
	endtask

	initial begin
		repeat (7)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_traffic(330, 0, 0);
		test_traffic(330, 45, 0);
		test_traffic(330, 0, 45);
		test_wrap(820);
		test_backpressure();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
